[rtl/fpa_pkg.sv]
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants of the signed Q24.8 fixed-point ALU
// Holds the data widths, the divider pipeline shape and the operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

  // Raw value width and number of fraction bits.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 8;
  localparam int OP_W   = 4;

  // The divider consumes the magnitude of operand_a shifted left by the
  // fraction bits; the magnitude of a negative full-scale value needs
  // DATA_W bits, so the shifted dividend needs DATA_W + FRAC_W bits.
  localparam int DIV_N      = DATA_W + FRAC_W;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = (DIV_N + DIV_STEP - 1) / DIV_STEP;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_FROM_INT = 4'd4,
    OP_TO_INT   = 4'd5,
    OP_CMP      = 4'd6,
    OP_MIN      = 4'd7,
    OP_MAX      = 4'd8,
    OP_INC      = 4'd9,
    OP_DEC      = 4'd10
  } fpa_op_t;

  // Everything that travels beside the divider until the final select.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] simple;
    logic [DATA_W-1:0] prod;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              qneg;
    logic              dz;
  } fpa_side_t;

endpackage

`default_nettype wire

[rtl/fpa_div.sv]
// ----------------------------------------------------------------------------
// fpa_div: pipelined unsigned restoring divider
// Produces DIV_STEP quotient bits per register stage; one beat may enter in
// every cycle and leaves after the last of the DIV_STAGES stage registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpa_div (
  input  wire logic                            clk,
  input  wire logic [fpa_pkg::DIV_N-1:0]       dividend,
  input  wire logic [fpa_pkg::DATA_W-1:0]      divisor,
  output logic      [fpa_pkg::DATA_W-1:0]      quotient
);

  localparam int NS = fpa_pkg::DIV_STAGES;
  localparam int DW = fpa_pkg::DATA_W;
  localparam int NW = fpa_pkg::DIV_N;

  // Per-stage state: partial remainder, dividend bits still to shift in
  // (quotient bits fill from the bottom) and the divisor.
  logic [DW-1:0] rem_r [NS];
  logic [NW-1:0] dq_r  [NS];
  logic [DW-1:0] d_r   [NS];

  // One restoring step: shift in the next dividend bit, trial subtract.
  function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [NW-1:0] dq,
                                                input logic [DW-1:0] d);
    logic [DW:0]   wide;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_o;
    logic [NW-1:0] dq_o;
    wide = {rem, dq[NW-1]};
    diff = wide - {1'b0, d};
    dq_o = {dq[NW-2:0], 1'b0};
    if (!diff[DW]) begin
      rem_o   = diff[DW-1:0];
      dq_o[0] = 1'b1;
    end else begin
      rem_o = wide[DW-1:0];
    end
    return {rem_o, dq_o};
  endfunction

  // Stage registers, each doing DIV_STEP dependent steps.
  always_ff @(posedge clk) begin
    logic [DW-1:0] rem;
    logic [NW-1:0] dq;
    logic [DW-1:0] d;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rem = '0;
        dq  = dividend;
        d   = divisor;
      end else begin
        rem = rem_r[s-1];
        dq  = dq_r[s-1];
        d   = d_r[s-1];
      end
      for (int k = 0; k < fpa_pkg::DIV_STEP; k++) begin
        if (s * fpa_pkg::DIV_STEP + k < NW) begin
          {rem, dq} = div_step(rem, dq, d);
        end
      end
      rem_r[s] <= rem;
      dq_r[s]  <= dq;
      d_r[s]   <= d;
    end
  end

  // After all steps the shift word holds the whole quotient.
  assign quotient = dq_r[NS-1][DW-1:0];

endmodule

`default_nettype wire

[rtl/fixed_point_q24_8_alu.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu: signed Q24.8 fixed-point arithmetic unit
// Every operation passes the input register, the stage-2 register, the DIV_STAGES
// stages of the pipelined divider and the output register. Throughput is one beat
// per cycle, so busy stays low and results appear as one-cycle strobes.
// Reset (synchronous, active low) clears only the valid bits of the stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_q24_8_alu (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic        [fpa_pkg::OP_W-1:0]   in_operation,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] in_operand_a,
  input  wire logic signed [fpa_pkg::DATA_W-1:0] in_operand_b,
  output logic                                   out_valid,
  output logic signed      [fpa_pkg::DATA_W-1:0] out_result_value,
  output logic                                   out_a_less,
  output logic                                   out_a_equal,
  output logic                                   out_a_greater,
  output logic                                   out_divide_by_zero
);

  localparam int DW = fpa_pkg::DATA_W;
  localparam int FW = fpa_pkg::FRAC_W;
  localparam int NS = fpa_pkg::DIV_STAGES;

  // Every stage takes a new beat in every cycle.
  assign busy = 1'b0;

  // Stage 1: input capture.
  logic                 s1_vld_r;
  logic [fpa_pkg::OP_W-1:0] s1_op_r;
  logic signed [DW-1:0] s1_a_r;
  logic signed [DW-1:0] s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
    s1_op_r <= in_operation;
    s1_a_r  <= in_operand_a;
    s1_b_r  <= in_operand_b;
  end

  // Stage 2 logic: compare, simple results, divider operands.
  logic              lt, eq, gt;
  logic [DW-1:0]     simple_nxt;
  logic [DW-1:0]     a_mag, b_mag;
  logic signed [DW-1:0] to_int_v;
  logic signed [2*DW-1:0] prod_full;

  assign lt = s1_a_r < s1_b_r;
  assign eq = s1_a_r == s1_b_r;
  assign gt = s1_a_r > s1_b_r;

  assign a_mag = s1_a_r[DW-1] ? DW'(-s1_a_r) : s1_a_r;
  assign b_mag = s1_b_r[DW-1] ? DW'(-s1_b_r) : s1_b_r;

  // Truncation toward zero: bias negative values before the shift.
  assign to_int_v = (s1_a_r + (s1_a_r[DW-1] ? DW'((1 << FW) - 1) : DW'(0))) >>> FW;

  // Full signed product; the scaled word is its middle slice.
  assign prod_full = s1_a_r * s1_b_r;

  always_comb begin
    unique case (fpa_pkg::fpa_op_t'(s1_op_r))
      fpa_pkg::OP_ADD:      simple_nxt = s1_a_r + s1_b_r;
      fpa_pkg::OP_SUB:      simple_nxt = s1_a_r - s1_b_r;
      fpa_pkg::OP_FROM_INT: simple_nxt = s1_a_r << FW;
      fpa_pkg::OP_TO_INT:   simple_nxt = to_int_v;
      fpa_pkg::OP_MIN:      simple_nxt = gt ? s1_b_r : s1_a_r;
      fpa_pkg::OP_MAX:      simple_nxt = lt ? s1_b_r : s1_a_r;
      fpa_pkg::OP_INC:      simple_nxt = s1_a_r + DW'(1);
      fpa_pkg::OP_DEC:      simple_nxt = s1_a_r - DW'(1);
      default:              simple_nxt = '0;
    endcase
  end

  // Stage 2 registers: scaled product, side information and divider operands.
  logic                   s2_vld_r;
  fpa_pkg::fpa_side_t     s2_side_r;
  logic [fpa_pkg::DIV_N-1:0] s2_dvd_r;
  logic [DW-1:0]          s2_dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_side_r.op   <= s1_op_r;
    s2_side_r.simple <= simple_nxt;
    s2_side_r.prod <= prod_full[FW+DW-1:FW];
    s2_side_r.lt   <= lt;
    s2_side_r.eq   <= eq;
    s2_side_r.gt   <= gt;
    s2_side_r.qneg <= s1_a_r[DW-1] ^ s1_b_r[DW-1];
    s2_side_r.dz   <= (s1_b_r == '0);
    s2_dvd_r       <= {a_mag, FW'(0)};
    s2_dvs_r       <= b_mag;
  end

  // Divider.
  logic [DW-1:0] quot;

  fpa_div u_div (
    .clk      (clk),
    .dividend (s2_dvd_r),
    .divisor  (s2_dvs_r),
    .quotient (quot)
  );

  // Delay line beside the divider.
  logic               dl_vld_r  [NS];
  fpa_pkg::fpa_side_t dl_side_r [NS];

  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (!rst_n) begin
        dl_vld_r[s] <= 1'b0;
      end else if (s == 0) begin
        dl_vld_r[s] <= s2_vld_r;
      end else begin
        dl_vld_r[s] <= dl_vld_r[s-1];
      end
      if (s == 0) begin
        dl_side_r[s] <= s2_side_r;
      end else begin
        dl_side_r[s] <= dl_side_r[s-1];
      end
    end
  end

  // Final select and output register.
  fpa_pkg::fpa_side_t fin;
  logic [DW-1:0]      result_nxt;
  logic               dz_nxt;

  assign fin = dl_side_r[NS-1];

  always_comb begin
    dz_nxt = 1'b0;
    unique case (fpa_pkg::fpa_op_t'(fin.op))
      fpa_pkg::OP_MUL: result_nxt = fin.prod;
      fpa_pkg::OP_DIV: begin
        dz_nxt = fin.dz;
        if (fin.dz) begin
          result_nxt = '0;
        end else begin
          result_nxt = fin.qneg ? DW'(-quot) : quot;
        end
      end
      default: result_nxt = fin.simple;
    endcase
  end

  logic          out_vld_r;
  logic [DW-1:0] out_res_r;
  logic          out_lt_r, out_eq_r, out_gt_r, out_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dl_vld_r[NS-1];
    end
    out_res_r <= result_nxt;
    out_lt_r  <= fin.lt;
    out_eq_r  <= fin.eq;
    out_gt_r  <= fin.gt;
    out_dz_r  <= dz_nxt;
  end

  assign out_valid          = out_vld_r;
  assign out_result_value   = out_res_r;
  assign out_a_less         = out_lt_r;
  assign out_a_equal        = out_eq_r;
  assign out_a_greater      = out_gt_r;
  assign out_divide_by_zero = out_dz_r;

endmodule

`default_nettype wire

[test/fixed_point_q24_8_alu_checker.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_checker: result predictor and scoreboard for the ALU
// Watches accepted operation beats, predicts each result from the operands,
// and compares every result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic        [fpa_pkg::OP_W-1:0]   in_operation,
  input  logic signed [fpa_pkg::DATA_W-1:0] in_operand_a,
  input  logic signed [fpa_pkg::DATA_W-1:0] in_operand_b,
  input  logic                              out_valid,
  input  logic signed [fpa_pkg::DATA_W-1:0] out_result_value,
  input  logic                              out_a_less,
  input  logic                              out_a_equal,
  input  logic                              out_a_greater,
  input  logic                              out_divide_by_zero,
  output int                                fail_count,
  output int                                pending_count,
  output int                                result_count
);
  import fpa_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Works out the result of one operation beat.
  function automatic alu_result_t alu_outcome(logic [OP_W-1:0] op,
                                              logic signed [DATA_W-1:0] a,
                                              logic signed [DATA_W-1:0] b);
    alu_result_t r;
    logic signed [2*DATA_W-1:0] product;
    logic signed [DATA_W+FRAC_W:0] dividend;
    logic signed [DATA_W+FRAC_W:0] quotient;
    logic signed [DATA_W-1:0] whole;
    r = '0;
    r.lt = a < b;
    r.eq = a == b;
    r.gt = a > b;
    case (op)
      OP_ADD:      r.value = a + b;
      OP_SUB:      r.value = a - b;
      OP_MUL: begin
        product = 64'(a) * 64'(b);
        r.value = product >>> FRAC_W;
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          // The widened dividend keeps every bit; SV division truncates to zero.
          dividend = 41'(a) <<< FRAC_W;
          quotient = dividend / 41'(b);
          r.value = quotient[DATA_W-1:0];
        end
      end
      OP_FROM_INT: r.value = a <<< FRAC_W;
      OP_TO_INT: begin
        whole = a / 32'sd256;
        r.value = whole;
      end
      OP_MIN:      r.value = (a > b) ? b : a;
      OP_MAX:      r.value = (a < b) ? b : a;
      OP_INC:      r.value = a + 1;
      OP_DEC:      r.value = a - 1;
      default:     r.value = '0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst_n) begin
      fail_count    <= 0;
      result_count  <= 0;
      pending_count <= 0;
      expected_results.delete();
    end else begin
      // Queue the prediction for an accepted operation beat.
      if (start && !busy)
        expected_results.push_back(alu_outcome(in_operation, in_operand_a, in_operand_b));
      // Compare a result beat with the oldest prediction.
      if (out_valid) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with nothing expected", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want.value != out_result_value || want.lt != out_a_less ||
              want.eq != out_a_equal || want.gt != out_a_greater ||
              want.dz != out_divide_by_zero) begin
            if (fail_count < 10)
              $display("%0t: expected value %h lt %b eq %b gt %b dz %b, got %h %b %b %b %b",
                       $realtime, want.value, want.lt, want.eq, want.gt, want.dz,
                       out_result_value, out_a_less, out_a_equal, out_a_greater,
                       out_divide_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_results.size();
    end
  end
endmodule

[test/fixed_point_q24_8_alu_tb.sv]
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_tb: stimulus and verdict for the Q24.8 fixed-point ALU
// Drives directed corner operands for every operation, then random beats with
// random gaps; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_tb;
  import fpa_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          in_operation = '0;
  logic signed [DATA_W-1:0] in_operand_a = '0;
  logic signed [DATA_W-1:0] in_operand_b = '0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_result_value;
  logic                     out_a_less;
  logic                     out_a_equal;
  logic                     out_a_greater;
  logic                     out_divide_by_zero;
  int                       fail_count;
  int                       pending_count;
  int                       result_count;
  int                       beats_sent = 0;

  always #5 clk = ~clk;

  fixed_point_q24_8_alu dut (.*);

  fixed_point_q24_8_alu_checker checker_inst (.*);

  // Picks an operand, weighted towards the interesting corners.
  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(0, 4)) - 2);
      3: return 32'(int'($urandom_range(0, 8192)) - 4096);
      4: return 32'(int'($urandom_range(0, 1)) ? 32'h0000_0100 : 32'hffff_ff00);
      default: return $urandom();
    endcase
  endfunction

  // Sends one operation beat, holding start until it is taken.
  task automatic send_beat(logic [OP_W-1:0] op, logic [DATA_W-1:0] a,
                           logic [DATA_W-1:0] b, bit keep_start);
    start        <= 1'b1;
    in_operation <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (busy);
    @(negedge clk);
    beats_sent++;
    if (!keep_start)
      start <= 1'b0;
  endtask

  // Random gap before a beat: mostly none or short, now and then long.
  task automatic idle_gap();
    int gap;
    case ($urandom_range(0, 19))
      0:       gap = $urandom_range(10, 40);
      1, 2, 3: gap = $urandom_range(1, 4);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    int waited;
    logic [OP_W-1:0] op;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: extremes, each operation, divide by zero, overflow.
    send_beat(OP_ADD,      32'h7fff_ffff, 32'h0000_0001, 1);
    send_beat(OP_SUB,      32'h8000_0000, 32'h0000_0001, 1);
    send_beat(OP_MUL,      32'h8000_0000, 32'h8000_0000, 1);
    send_beat(OP_MUL,      32'hffff_ff80, 32'h0000_0100, 1);
    send_beat(OP_DIV,      32'h0000_1000, 32'h0000_0000, 1);
    send_beat(OP_DIV,      32'h8000_0000, 32'hffff_ffff, 1);
    send_beat(OP_DIV,      32'h7fff_ffff, 32'h0000_0001, 1);
    send_beat(OP_DIV,      32'hffff_fd00, 32'h0000_0200, 1);
    send_beat(OP_FROM_INT, 32'h00ff_ffff, 32'h0, 1);
    send_beat(OP_FROM_INT, 32'h8000_0001, 32'h0, 1);
    send_beat(OP_TO_INT,   32'hffff_fe80, 32'h0, 1);
    send_beat(OP_TO_INT,   32'h8000_0000, 32'h0, 1);
    send_beat(OP_CMP,      32'h1234_5678, 32'h1234_5678, 1);
    send_beat(OP_MIN,      32'h8000_0000, 32'h7fff_ffff, 1);
    send_beat(OP_MAX,      32'h0000_0180, 32'h0000_01ff, 1);
    send_beat(OP_INC,      32'h7fff_ffff, 32'h0, 1);
    send_beat(OP_DEC,      32'h8000_0000, 32'h0, 1);
    send_beat(4'd11,       32'h0000_0005, 32'hffff_ffff, 1);
    send_beat(4'd15,       32'hffff_ffff, 32'hffff_ffff, 1);

    // Random operations with random gaps; unknown codes appear now and then.
    repeat (1800) begin
      idle_gap();
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(11, 15))
                                        : 4'($urandom_range(0, 10));
      send_beat(op, pick_operand(), pick_operand(), 1);
    end
    start <= 1'b0;

    // Drain outstanding results, then allow for the pipeline depth.
    waited = 0;
    while (pending_count != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DIV_STAGES + 10) @(posedge clk);
    $display("Sent %0d operation beats, checked %0d result beats.", beats_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule

[files.f]
rtl/fpa_pkg.sv
rtl/fpa_div.sv
rtl/fixed_point_q24_8_alu.sv
test/fixed_point_q24_8_alu_checker.sv
test/fixed_point_q24_8_alu_tb.sv
